@@ design/pfe_pkg.sv @@
// Shared types, register codes and fixed-point helpers for the power estimator.
package pfe_pkg;

    // Collective demand is taken as one minus collective when set
    localparam bit LEAD_INVERT = 1'b0;

    // Pipeline depth, output register included
    localparam int NSTAGE = 7;

    // Q1.15 unity
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUEL_MIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUEL_SCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_NOMINAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_DROP_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_POWER_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAIN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_DEADBAND   = 3'd7;

    // Source mode codes
    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_COLLECTIVE = 3'd1;
    localparam logic [2:0] MODE_FUEL       = 3'd2;
    localparam logic [2:0] MODE_FUEL_RPM   = 3'd3;

    typedef enum logic [3:0] {
        ST_OFF          = 4'd0,
        ST_COLL         = 4'd1,
        ST_COLL_MISSING = 4'd2,
        ST_FF_MISSING   = 4'd3,
        ST_FF           = 4'd4,
        ST_FF_LEAD      = 4'd5,
        ST_FR_MISSING   = 4'd6,
        ST_FR           = 4'd7,
        ST_FR_LEAD      = 4'd8,
        ST_INVALID      = 4'd9
    } status_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        status_t            status;
        logic               present;
        logic               fuel;
        logic               rpm_use;
        logic               coll_ok;
        logic signed [16:0] coll;
    } item_ctl_t;

    // Clamp a signed value to 0..1.0 in Q1.15
    function automatic logic [16:0] clamp_unit(input logic signed [22:0] v);
        logic [16:0] r;
        if (v < 0)
            r = 17'd0;
        else if (v > $signed({6'd0, ONE_Q15}))
            r = ONE_Q15;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

@@ design/pfe_if.sv @@
// Sample and result channel interfaces.
interface pfe_sample_if;
    import pfe_pkg::*;

    logic               valid;
    logic               ready;
    logic [15:0]        fuel_rate;
    logic               fuel_rate_present;
    logic [15:0]        rpm;
    logic               rpm_present;
    logic signed [16:0] collective;
    logic               collective_present;

    modport source (
        output valid, fuel_rate, fuel_rate_present, rpm, rpm_present,
               collective, collective_present,
        input  ready
    );
    modport sink (
        input  valid, fuel_rate, fuel_rate_present, rpm, rpm_present,
               collective, collective_present,
        output ready
    );
endinterface

interface pfe_result_if;
    import pfe_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [16:0] power_value;
    logic               value_present;
    status_t            status;

    modport source (
        output valid, power_value, value_present, status,
        input  ready
    );
    modport sink (
        input  valid, power_value, value_present, status,
        output ready
    );
endinterface

@@ design/pfe_scaler.sv @@
// Magnitude times reciprocal scale, registered product, saturated Q1.15 result.
module pfe_scaler (
    input  logic        clk,
    input  logic        load,
    input  logic [15:0] mag,
    input  logic [23:0] scale,
    output logic [16:0] norm
);
    import pfe_pkg::*;

    logic [39:0] prod_reg;
    logic [23:0] quot;

    // 16x24 product, taken when the stage advances
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= mag * scale;
        end
    end

    // Drop the 16 fraction bits and saturate at one
    assign quot = prod_reg[39:16];
    assign norm = (quot > {7'd0, ONE_Q15}) ? ONE_Q15 : quot[16:0];

endmodule

@@ design/power_feedforward_estimator_core.sv @@
// Top level: seven-stage power estimate pipeline with configuration registers.
// Throughput: one sample per cycle while the result side is not stalled;
//   every stage advances on its own, so bubbles close up.
// Stages: scale multiply, saturate, rpm gain multiply, sum and clamp, lead error,
//   lead gain multiply, final clamp into the output register.
// Reset: all configuration registers clear to zero (mode off), pipeline empties.
module power_feedforward_estimator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0] wr_data,
    pfe_sample_if.sink                     sample,
    pfe_result_if.source                   result
);
    import pfe_pkg::*;

    // Configuration registers
    logic [2:0]         mode_reg;
    logic [15:0]        ff_min_reg;
    logic [23:0]        ff_scale_reg;
    logic [15:0]        rpm_nom_reg;
    logic [23:0]        rpm_scale_reg;
    logic signed [17:0] rpm_gain_reg;
    logic signed [17:0] lead_gain_reg;
    logic signed [15:0] deadband_reg;

    // Stage control
    logic [1:NSTAGE]    valid_reg;
    logic [1:NSTAGE]    en;

    // Stage payload
    item_ctl_t          ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;
    logic               rpm_neg1_reg;
    logic [16:0]        est2_reg, est3_reg, est4_reg, est5_reg, est6_reg;
    logic signed [16:0] drop2_reg;
    logic signed [34:0] corr3_reg;
    logic [16:0]        demand4_reg;
    logic signed [18:0] err5_reg;
    logic               lead5_reg, lead6_reg;
    logic signed [36:0] lead6_prod_reg;
    logic signed [16:0] out_val_reg;
    logic               out_present_reg;
    status_t            out_status_reg;

    // Combinational values
    item_ctl_t          ctl1_next;
    logic [15:0]        ff_mag, rpm_mag;
    logic               rpm_ge;
    logic [16:0]        ff_norm, rpm_norm;
    logic signed [16:0] drop2_next;
    logic signed [19:0] corr4;
    logic signed [20:0] sum4;
    logic [16:0]        est4_next, demand4_next, demand_clamped;
    logic signed [18:0] err5_next;
    logic               lead_pos, lead5_next;
    logic signed [21:0] lead_inc;
    logic signed [22:0] lead_sum;
    logic signed [16:0] out_val_next;
    status_t            out_status_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            ff_min_reg    <= '0;
            ff_scale_reg  <= '0;
            rpm_nom_reg   <= '0;
            rpm_scale_reg <= '0;
            rpm_gain_reg  <= '0;
            lead_gain_reg <= '0;
            deadband_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SOURCE_MODE:     mode_reg      <= wr_data[2:0];
                CFG_FUEL_MIN:        ff_min_reg    <= wr_data[15:0];
                CFG_FUEL_SCALE:      ff_scale_reg  <= wr_data[23:0];
                CFG_RPM_NOMINAL:     rpm_nom_reg   <= wr_data[15:0];
                CFG_RPM_DROP_SCALE:  rpm_scale_reg <= wr_data[23:0];
                CFG_RPM_POWER_GAIN:  rpm_gain_reg  <= wr_data[17:0];
                CFG_LEAD_GAIN:       lead_gain_reg <= wr_data[17:0];
                CFG_LEAD_DEADBAND:   deadband_reg  <= wr_data[15:0];
                default:             ;
            endcase
        end
    end

    // Per-stage advance: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NSTAGE] = !valid_reg[NSTAGE] || result.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign sample.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= sample.valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: mode decode, magnitudes into the scale multipliers
    assign ff_mag  = (sample.fuel_rate > ff_min_reg) ? (sample.fuel_rate - ff_min_reg) : 16'd0;
    assign rpm_ge  = (rpm_nom_reg >= sample.rpm);
    assign rpm_mag = rpm_ge ? (rpm_nom_reg - sample.rpm) : (sample.rpm - rpm_nom_reg);

    always_comb
    begin
        ctl1_next.status  = ST_INVALID;
        ctl1_next.present = 1'b0;
        ctl1_next.fuel    = 1'b0;
        ctl1_next.rpm_use = 1'b0;
        ctl1_next.coll_ok = sample.collective_present;
        ctl1_next.coll    = sample.collective;
        case (mode_reg)
            MODE_OFF:
            begin
                ctl1_next.status = ST_OFF;
            end
            MODE_COLLECTIVE:
            begin
                ctl1_next.status  = sample.collective_present ? ST_COLL : ST_COLL_MISSING;
                ctl1_next.present = sample.collective_present;
            end
            MODE_FUEL:
            begin
                ctl1_next.status  = sample.fuel_rate_present ? ST_FF : ST_FF_MISSING;
                ctl1_next.present = sample.fuel_rate_present;
                ctl1_next.fuel    = sample.fuel_rate_present;
            end
            MODE_FUEL_RPM:
            begin
                ctl1_next.status  = sample.fuel_rate_present ? ST_FR : ST_FR_MISSING;
                ctl1_next.present = sample.fuel_rate_present;
                ctl1_next.fuel    = sample.fuel_rate_present;
                ctl1_next.rpm_use = sample.rpm_present;
            end
            default:
            begin
                ctl1_next.status = ST_INVALID;
            end
        endcase
    end

    pfe_scaler u_ff_scaler (
        .clk   (clk),
        .load  (en[1]),
        .mag   (ff_mag),
        .scale (ff_scale_reg),
        .norm  (ff_norm)
    );

    pfe_scaler u_rpm_scaler (
        .clk   (clk),
        .load  (en[1]),
        .mag   (rpm_mag),
        .scale (rpm_scale_reg),
        .norm  (rpm_norm)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ctl1_reg     <= ctl1_next;
            rpm_neg1_reg <= !rpm_ge;
        end
    end

    // Stage 2: saturated fuel term and signed droop
    assign drop2_next = rpm_neg1_reg ? -$signed(rpm_norm) : $signed(rpm_norm);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ctl2_reg  <= ctl1_reg;
            est2_reg  <= ff_norm;
            drop2_reg <= drop2_next;
        end
    end

    // Stage 3: rpm gain times droop
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ctl3_reg  <= ctl2_reg;
            est3_reg  <= est2_reg;
            corr3_reg <= rpm_gain_reg * drop2_reg;
        end
    end

    // Stage 4: add floored correction, clamp; clamp collective demand
    assign corr4     = ctl3_reg.rpm_use ? corr3_reg[34:15] : 20'sd0;
    assign sum4      = $signed({4'd0, est3_reg}) + {corr4[19], corr4};
    assign est4_next = clamp_unit({{2{sum4[20]}}, sum4});
    assign demand_clamped = clamp_unit({{6{ctl3_reg.coll[16]}}, ctl3_reg.coll});
    assign demand4_next   = LEAD_INVERT ? (ONE_Q15 - demand_clamped) : demand_clamped;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ctl4_reg    <= ctl3_reg;
            est4_reg    <= est4_next;
            demand4_reg <= demand4_next;
        end
    end

    // Stage 5: lead error and lead enable
    assign err5_next = $signed({2'd0, demand4_reg}) - $signed({2'd0, est4_reg})
                       - {{3{deadband_reg[15]}}, deadband_reg};
    assign lead_pos   = !lead_gain_reg[17] && (lead_gain_reg != 18'sd0);
    assign lead5_next = ctl4_reg.fuel && ctl4_reg.coll_ok && lead_pos
                        && !err5_next[18] && (err5_next != 19'sd0);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ctl5_reg  <= ctl4_reg;
            est5_reg  <= est4_reg;
            err5_reg  <= err5_next;
            lead5_reg <= lead5_next;
        end
    end

    // Stage 6: lead gain times error
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            ctl6_reg       <= ctl5_reg;
            est6_reg       <= est5_reg;
            lead6_reg      <= lead5_reg;
            lead6_prod_reg <= lead_gain_reg * err5_reg;
        end
    end

    // Stage 7: apply lead, pick value and status
    assign lead_inc = lead6_prod_reg[36:15];
    assign lead_sum = $signed({6'd0, est6_reg}) + {lead_inc[21], lead_inc};

    always_comb
    begin
        out_status_next = ctl6_reg.status;
        if (!ctl6_reg.present)
            out_val_next = 17'sd0;
        else if (!ctl6_reg.fuel)
            out_val_next = ctl6_reg.coll;
        else if (lead6_reg)
            out_val_next = $signed(clamp_unit(lead_sum));
        else
            out_val_next = $signed(est6_reg);
        if (lead6_reg)
        begin
            case (ctl6_reg.status)
                ST_FF:   out_status_next = ST_FF_LEAD;
                ST_FR:   out_status_next = ST_FR_LEAD;
                default: out_status_next = ctl6_reg.status;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            out_val_reg     <= out_val_next;
            out_present_reg <= ctl6_reg.present;
            out_status_reg  <= out_status_next;
        end
    end

    assign result.valid         = valid_reg[NSTAGE];
    assign result.power_value   = out_val_reg;
    assign result.value_present = out_present_reg;
    assign result.status        = out_status_reg;

    // A blocked input means the whole pipe is full behind a stalled result
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (valid_reg == '1) && !result.ready)
        else $error("input blocked while pipeline has room");

    // An absent value always reads as zero
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.value_present |-> result.power_value == 17'sd0)
        else $error("absent value not zero");

    // Presence agrees with the status code
    a_present_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.value_present |->
            (result.status == ST_COLL) || (result.status == ST_FF)
            || (result.status == ST_FF_LEAD) || (result.status == ST_FR)
            || (result.status == ST_FR_LEAD))
        else $error("value present with a no-value status");

    // Fuel-based estimates stay within 0..1
    a_fuel_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.value_present && (result.status != ST_COLL) |->
            !result.power_value[16] && (result.power_value <= $signed(ONE_Q15)))
        else $error("fuel estimate outside unit range");

endmodule

@@ sim/power_feedforward_estimator_core_tb.sv @@
// Self-checking testbench for the power feedforward estimator core.
module power_feedforward_estimator_core_tb;
    import pfe_pkg::*;

    localparam longint UNITY = 32768;

    // One sensor sample; drain holds the item back until all results are in
    typedef struct {
        logic [15:0]        ff;
        logic               ff_ok;
        logic [15:0]        rpm;
        logic               rpm_ok;
        logic signed [16:0] coll;
        logic               coll_ok;
        bit                 drain;
    } sample_t;

    typedef struct {
        logic signed [16:0] pwr;
        logic               pres;
        status_t            st;
    } power_est_t;

    typedef struct {
        logic [2:0]         mode;
        logic [15:0]        ffmin;
        logic [23:0]        ffscale;
        logic [15:0]        rpmnom;
        logic [23:0]        rpmscale;
        logic signed [17:0] rpmgain;
        logic signed [17:0] leadgain;
        logic signed [15:0] deadband;
    } est_cfg_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    pfe_sample_if smp ();
    pfe_result_if res ();

    power_feedforward_estimator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (smp),
        .result   (res)
    );

    sample_t    pending_q [$];
    power_est_t expected_q [$];
    est_cfg_t   cfg;
    int         err_cnt;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Clamp to 0..1.0 in Q1.15
    function automatic longint clamp01(input longint v);
        if (v < 0)
            return 0;
        if (v > UNITY)
            return UNITY;
        return v;
    endfunction

    // Magnitude times reciprocal span, truncated and saturated at 1.0
    function automatic longint sat_scale(input longint mag, input longint sc);
        longint q;
        q = (mag * sc) >>> 16;
        return (q > UNITY) ? UNITY : q;
    endfunction

    // Expected result of one sample under the current register copy
    function automatic power_est_t estimate_power(input sample_t s);
        power_est_t r;
        longint     est;
        longint     drop;
        longint     dem;
        longint     err;
        bit         fr;
        bit         lead_on;
        r.pwr   = '0;
        r.pres  = 1'b0;
        r.st    = ST_OFF;
        lead_on = 1'b0;
        case (cfg.mode)
            MODE_OFF:
                r.st = ST_OFF;
            MODE_COLLECTIVE:
            begin
                if (s.coll_ok)
                begin
                    r.pwr  = s.coll;
                    r.pres = 1'b1;
                    r.st   = ST_COLL;
                end
                else
                    r.st = ST_COLL_MISSING;
            end
            MODE_FUEL, MODE_FUEL_RPM:
            begin
                fr = (cfg.mode == MODE_FUEL_RPM);
                if (!s.ff_ok)
                    r.st = fr ? ST_FR_MISSING : ST_FF_MISSING;
                else
                begin
                    est = 0;
                    if (s.ff > cfg.ffmin)
                        est = sat_scale(longint'(s.ff) - longint'(cfg.ffmin),
                                        longint'(cfg.ffscale));
                    if (fr)
                    begin
                        // rpm droop correction, floor of the Q15 product
                        if (s.rpm_ok)
                        begin
                            if (cfg.rpmnom >= s.rpm)
                                drop = sat_scale(longint'(cfg.rpmnom) - longint'(s.rpm),
                                                 longint'(cfg.rpmscale));
                            else
                                drop = -sat_scale(longint'(s.rpm) - longint'(cfg.rpmnom),
                                                  longint'(cfg.rpmscale));
                            est = est + ((longint'(cfg.rpmgain) * drop) >>> 15);
                        end
                        est = clamp01(est);
                    end
                    // collective lead toward demand
                    if (cfg.leadgain > 0 && s.coll_ok)
                    begin
                        dem = clamp01(longint'(s.coll));
                        if (LEAD_INVERT)
                            dem = UNITY - dem;
                        err = dem - est - longint'(cfg.deadband);
                        if (err > 0)
                        begin
                            lead_on = 1'b1;
                            est = clamp01(est + ((longint'(cfg.leadgain) * err) >>> 15));
                        end
                    end
                    r.pwr  = 17'(est);
                    r.pres = 1'b1;
                    if (fr)
                        r.st = lead_on ? ST_FR_LEAD : ST_FR;
                    else
                        r.st = lead_on ? ST_FF_LEAD : ST_FF;
                end
            end
            default:
                r.st = ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic sample_t mk(input logic [15:0] ff, input bit ff_ok,
                                   input logic [15:0] rpm, input bit rpm_ok,
                                   input logic signed [16:0] coll, input bit coll_ok);
        sample_t s;
        s.ff      = ff;
        s.ff_ok   = ff_ok;
        s.rpm     = rpm;
        s.rpm_ok  = rpm_ok;
        s.coll    = coll;
        s.coll_ok = coll_ok;
        s.drain   = 1'b0;
        return s;
    endfunction

    // Sample driver
    sample_t cur_smp;
    bit      smp_busy;
    bit      smp_burst;
    int      smp_gap;
    logic    nxt_valid;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
            smp_busy  = 1'b0;
            smp_burst = 1'b0;
            smp_gap   = 0;
        end
        else
        begin
            nxt_valid = smp.valid;
            // beat taken: record the answer owed for it
            if (smp.valid && smp.ready)
            begin
                expected_q.push_back(estimate_power(cur_smp));
                smp_busy  = 1'b0;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    smp_burst = !smp_burst;
                smp_gap = smp_burst ? 0 : $urandom_range(0, 10);
            end
            if (!nxt_valid)
            begin
                if (smp_gap > 0)
                    smp_gap--;
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && expected_q.size() > 0))
                begin
                    cur_smp = pending_q.pop_front();
                    smp_busy = 1'b1;
                    smp.fuel_rate          <= cur_smp.ff;
                    smp.fuel_rate_present  <= cur_smp.ff_ok;
                    smp.rpm                <= cur_smp.rpm;
                    smp.rpm_present        <= cur_smp.rpm_ok;
                    smp.collective         <= cur_smp.coll;
                    smp.collective_present <= cur_smp.coll_ok;
                    nxt_valid = 1'b1;
                end
            end
            smp.valid <= nxt_valid;
        end
    end

    // Result monitor and receiver stalls
    power_est_t want;
    bit         rcv_burst;
    int         rcv_stall;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            rcv_burst = 1'b0;
            rcv_stall = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    err_cnt++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res.power_value !== want.pwr)
                    begin
                        $error("power_value: expected %0d, got %0d", want.pwr, res.power_value);
                        err_cnt++;
                    end
                    if (res.value_present !== want.pres)
                    begin
                        $error("value_present: expected %0d, got %0d",
                               want.pres, res.value_present);
                        err_cnt++;
                    end
                    if (res.status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, res.status);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rcv_burst = !rcv_burst;
                rcv_stall = rcv_burst ? 0 : $urandom_range(0, 10);
            end
            if (rcv_stall > 0)
            begin
                rcv_stall--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Wait for the pipeline to empty, then let the latency pass
    task automatic wait_idle();
        while (pending_q.size() != 0 || smp_busy || expected_q.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 2) @(posedge clk);
    endtask

    // Write every register; only called while idle
    task automatic load_config(input est_cfg_t c);
        logic [CFG_DATA_W-1:0] v [8];
        v[CFG_SOURCE_MODE]     = CFG_DATA_W'(c.mode);
        v[CFG_FUEL_MIN]        = CFG_DATA_W'(c.ffmin);
        v[CFG_FUEL_SCALE]      = c.ffscale;
        v[CFG_RPM_NOMINAL]     = CFG_DATA_W'(c.rpmnom);
        v[CFG_RPM_DROP_SCALE]  = c.rpmscale;
        v[CFG_RPM_POWER_GAIN]  = CFG_DATA_W'(c.rpmgain);
        v[CFG_LEAD_GAIN]       = CFG_DATA_W'(c.leadgain);
        v[CFG_LEAD_DEADBAND]   = CFG_DATA_W'(c.deadband);
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            wr_en    <= 1'b1;
            wr_index <= i[CFG_IDX_W-1:0];
            wr_data  <= v[i];
        end
        @(posedge clk);
        wr_en <= 1'b0;
        cfg = c;
    endtask

    // Stimulus
    initial
    begin : stim
        est_cfg_t c;
        sample_t  s;
        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;
        smp.valid = 1'b0;
        smp.fuel_rate          = '0;
        smp.fuel_rate_present  = 1'b0;
        smp.rpm                = '0;
        smp.rpm_present        = 1'b0;
        smp.collective         = '0;
        smp.collective_present = 1'b0;
        res.ready = 1'b0;
        err_cnt   = 0;
        cfg       = '{default: '0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: mode off
        pending_q.push_back(mk(16'hFFFF, 1, 16'hFFFF, 1, 17'h10000, 1));
        pending_q.push_back(mk(16'h0000, 0, 16'h0000, 0, 17'h00000, 0));
        wait_idle();

        // collective pass-through, extremes and missing reading
        c = cfg;
        c.mode = MODE_COLLECTIVE;
        load_config(c);
        pending_q.push_back(mk(16'd0, 0, 16'd0, 0, 17'h10000, 1));
        pending_q.push_back(mk(16'd0, 0, 16'd0, 0, 17'h0FFFF, 1));
        pending_q.push_back(mk(16'd0, 0, 16'd0, 0, 17'd32768, 1));
        pending_q.push_back(mk(16'd0, 0, 16'd0, 0, 17'd1234, 0));
        wait_idle();

        // fuel flow: at and below minimum, full-scale reading, missing, mid span
        c.mode = MODE_FUEL;
        c.ffmin = 16'd1000;
        c.ffscale = 24'd2048;
        load_config(c);
        pending_q.push_back(mk(16'd1000, 1, 16'd0, 0, 17'd0, 1));
        pending_q.push_back(mk(16'd999, 1, 16'd0, 0, 17'd0, 1));
        pending_q.push_back(mk(16'hFFFF, 1, 16'hFFFF, 1, 17'd0, 1));
        pending_q.push_back(mk(16'd5000, 0, 16'd0, 1, 17'd0, 1));
        pending_q.push_back(mk(16'd17000, 1, 16'd0, 0, 17'd0, 0));
        wait_idle();

        // fuel flow with maximum lead gain and most negative deadband
        c.leadgain = 18'h1FFFF;
        c.deadband = 16'h8000;
        load_config(c);
        pending_q.push_back(mk(16'd1000, 1, 16'd0, 0, 17'd32768, 1));
        pending_q.push_back(mk(16'd1000, 1, 16'd0, 0, 17'd32768, 0));
        pending_q.push_back(mk(16'd9000, 1, 16'd0, 0, 17'h10000, 1));
        wait_idle();

        // fuel plus rpm: full scales, most negative gain, lead disabled
        c.mode = MODE_FUEL_RPM;
        c.ffmin = 16'd0;
        c.ffscale = 24'hFFFFFF;
        c.rpmnom = 16'd30000;
        c.rpmscale = 24'hFFFFFF;
        c.rpmgain = 18'h20000;
        c.leadgain = -18'sd5;
        c.deadband = 16'h7FFF;
        load_config(c);
        pending_q.push_back(mk(16'd1, 1, 16'd0, 0, 17'd32768, 1));
        pending_q.push_back(mk(16'd1, 1, 16'd0, 1, 17'd32768, 1));
        pending_q.push_back(mk(16'd1, 1, 16'hFFFF, 1, 17'd0, 1));
        pending_q.push_back(mk(16'd1, 1, 16'd30000, 1, 17'd0, 1));
        pending_q.push_back(mk(16'd1, 0, 16'd0, 1, 17'd0, 1));
        wait_idle();

        // zero scales with lead of one half
        c.ffscale = 24'd0;
        c.rpmscale = 24'd0;
        c.rpmgain = 18'h1FFFF;
        c.leadgain = 18'sd16384;
        c.deadband = 16'sd0;
        load_config(c);
        pending_q.push_back(mk(16'hFFFF, 1, 16'd0, 1, 17'd32768, 1));
        pending_q.push_back(mk(16'hFFFF, 1, 16'd0, 1, 17'd0, 1));
        wait_idle();

        // unknown mode codes
        c.mode = 3'd4;
        load_config(c);
        pending_q.push_back(mk(16'd100, 1, 16'd100, 1, 17'd100, 1));
        wait_idle();
        c.mode = 3'd7;
        load_config(c);
        pending_q.push_back(mk(16'd100, 1, 16'd100, 1, 17'd100, 1));
        wait_idle();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 19))
                0:                        c.mode = MODE_OFF;
                1, 2:                     c.mode = MODE_COLLECTIVE;
                3, 4, 5, 6, 7, 8, 9:      c.mode = MODE_FUEL;
                10, 11, 12, 13, 14, 15,
                16, 17, 18:               c.mode = MODE_FUEL_RPM;
                default:                  c.mode = 3'($urandom_range(4, 7));
            endcase
            c.ffmin  = 16'($urandom);
            c.rpmnom = 16'($urandom);
            case ($urandom_range(0, 3))
                0:       c.ffscale = 24'd0;
                1:       c.ffscale = 24'hFFFFFF;
                2:       c.ffscale = 24'($urandom_range(32, 65536));
                default: c.ffscale = 24'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       c.rpmscale = 24'd0;
                1:       c.rpmscale = 24'hFFFFFF;
                2:       c.rpmscale = 24'($urandom_range(32, 65536));
                default: c.rpmscale = 24'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       c.rpmgain = 18'h20000;
                1:       c.rpmgain = 18'h1FFFF;
                2:       c.rpmgain = 18'($urandom);
                default: c.rpmgain = 18'($urandom_range(0, 65536) - 32768);
            endcase
            case ($urandom_range(0, 4))
                0:       c.leadgain = 18'h1FFFF;
                1:       c.leadgain = 18'($urandom);
                2:       c.leadgain = 18'($urandom_range(0, 131072) - 131072);
                default: c.leadgain = 18'($urandom_range(1, 65536));
            endcase
            case ($urandom_range(0, 3))
                0:       c.deadband = 16'h8000;
                1:       c.deadband = 16'h7FFF;
                2:       c.deadband = 16'($urandom);
                default: c.deadband = 16'($urandom_range(0, 2048) - 1024);
            endcase
            // corners: everything at its top, then everything at its bottom
            if (ph == 0)
            begin
                c.mode = MODE_FUEL_RPM;
                c.ffmin = 16'hFFFF;
                c.ffscale = 24'hFFFFFF;
                c.rpmnom = 16'hFFFF;
                c.rpmscale = 24'hFFFFFF;
                c.rpmgain = 18'h1FFFF;
                c.leadgain = 18'h1FFFF;
                c.deadband = 16'h7FFF;
            end
            else if (ph == 1)
            begin
                c.mode = MODE_FUEL_RPM;
                c.ffmin = 16'd0;
                c.ffscale = 24'd0;
                c.rpmnom = 16'd0;
                c.rpmscale = 24'd0;
                c.rpmgain = 18'h20000;
                c.leadgain = 18'h20000;
                c.deadband = 16'h8000;
            end
            load_config(c);

            for (int n = 0; n < 140; n++)
            begin
                // half the readings near the programmed operating point
                if ($urandom_range(0, 1) == 0)
                    s.ff = 16'($urandom);
                else
                    s.ff = c.ffmin + 16'($urandom_range(0, 2048)) - 16'd256;
                if ($urandom_range(0, 1) == 0)
                    s.rpm = 16'($urandom);
                else
                    s.rpm = c.rpmnom + 16'($urandom_range(0, 4096)) - 16'd2048;
                if ($urandom_range(0, 9) < 7)
                    s.coll = 17'($urandom_range(0, 32768));
                else
                    s.coll = 17'($urandom);
                s.ff_ok   = ($urandom_range(0, 9) != 0);
                s.rpm_ok  = ($urandom_range(0, 9) != 0);
                s.coll_ok = ($urandom_range(0, 9) != 0);
                s.drain   = ($urandom_range(0, 199) == 0) || (ph == 3 && n == 60);
                pending_q.push_back(s);
            end
            wait_idle();
        end

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
